@@ sv/crl_pkg.sv @@
// Shared types, constants and helpers for the core image record loader.
`default_nettype none

package crl_pkg;

    localparam int HALF_W  = 18;
    localparam int WORD_W  = 36;
    localparam int BYTE_W  = 8;
    localparam int PHASE_W = 3;

    // Phase of the fifth byte, which completes a word.
    localparam logic [PHASE_W-1:0] LAST_PHASE = 3'd4;

    // Left half that marks the end header carrying the start jump, after reset.
    localparam logic [HALF_W-1:0] START_JUMP_RESET = 18'o254000;

    localparam logic [5:0] SHIFT_B0 = 6'd28;
    localparam logic [5:0] SHIFT_B1 = 6'd20;
    localparam logic [5:0] SHIFT_B2 = 6'd12;
    localparam logic [5:0] SHIFT_B3 = 6'd4;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_START = 2'd1,
        KIND_END   = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [HALF_W-1:0]  target_address;
        logic [WORD_W-1:0]  word_value;
    } result_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               in_record;
    } parse_status_t;

    // Bit position of a byte within the 36-bit word, by its place in the word.
    function automatic logic [5:0] byte_shift(input logic [PHASE_W-1:0] phase);
        logic [5:0] sh;
        unique case (phase)
            3'd0:    sh = SHIFT_B0;
            3'd1:    sh = SHIFT_B1;
            3'd2:    sh = SHIFT_B2;
            3'd3:    sh = SHIFT_B3;
            default: sh = 6'd0;
        endcase
        return sh;
    endfunction

endpackage

`default_nettype wire

@@ sv/crl_parser.sv @@
// Word packing and header/record parsing for one byte per step.
`default_nettype none

module crl_parser (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          step,
    input  wire logic [crl_pkg::BYTE_W-1:0]    byte_value,
    input  wire logic                          restart,
    input  wire logic [crl_pkg::HALF_W-1:0]    start_jump_half,
    output logic                               res_valid,
    output crl_pkg::result_t                   res,
    output crl_pkg::parse_status_t             status
);
    import crl_pkg::*;

    logic [PHASE_W-1:0] phase_reg, phase_next, phase_cur;
    logic [WORD_W-1:0]  acc_reg, acc_next, acc_cur;
    logic               in_rec_reg, in_rec_next, in_rec_cur;
    logic [HALF_W-1:0]  left_reg, left_next, left_cur;
    logic [HALF_W-1:0]  addr_reg, addr_next, addr_cur;

    logic [WORD_W-1:0]  byte_ext;
    logic [WORD_W-1:0]  word;
    logic [HALF_W-1:0]  lh, rh, left_inc;

    always_comb
    begin
        // Restart wipes parse state before this byte is taken.
        phase_cur  = restart ? '0 : phase_reg;
        acc_cur    = restart ? '0 : acc_reg;
        in_rec_cur = restart ? 1'b0 : in_rec_reg;
        left_cur   = restart ? '0 : left_reg;
        addr_cur   = restart ? '0 : addr_reg;

        byte_ext = {{(WORD_W-BYTE_W){1'b0}}, byte_value};
        word     = acc_cur | byte_ext;
        lh       = word[WORD_W-1:HALF_W];
        rh       = word[HALF_W-1:0];
        left_inc = left_cur + 1'b1;

        phase_next  = phase_cur;
        acc_next    = acc_cur;
        in_rec_next = in_rec_cur;
        left_next   = left_cur;
        addr_next   = addr_cur;
        res_valid   = 1'b0;
        res         = '{kind: KIND_WRITE, target_address: '0, word_value: '0};

        priority if (phase_cur < LAST_PHASE)
        begin
            acc_next   = acc_cur | (byte_ext << byte_shift(phase_cur));
            phase_next = phase_cur + 1'b1;
        end
        else
        begin
            acc_next   = '0;
            phase_next = '0;
            priority if (in_rec_cur)
            begin
                res_valid = 1'b1;
                res       = '{kind: KIND_WRITE, target_address: addr_cur, word_value: word};
                addr_next = addr_cur + 1'b1;
                left_next = left_inc;
                if (!left_inc[HALF_W-1])
                begin
                    in_rec_next = 1'b0;
                end
            end
            else if (lh[HALF_W-1])
            begin
                // Record header: negative count, start address minus one.
                left_next   = lh;
                addr_next   = rh + 1'b1;
                in_rec_next = 1'b1;
            end
            else if (lh == start_jump_half)
            begin
                res_valid = 1'b1;
                res       = '{kind: KIND_START, target_address: '0, word_value: word};
            end
            else
            begin
                res_valid = 1'b1;
                res       = '{kind: KIND_END, target_address: '0, word_value: '0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= '0;
            acc_reg    <= '0;
            in_rec_reg <= 1'b0;
            left_reg   <= '0;
            addr_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            acc_reg    <= acc_next;
            in_rec_reg <= in_rec_next;
            left_reg   <= left_next;
            addr_reg   <= addr_next;
        end
    end

    assign status = '{phase: phase_reg, in_record: in_rec_reg};

endmodule

`default_nettype wire

@@ sv/crl_result_reg.sv @@
// Output register holding one result transaction until the receiver takes it.
`default_nettype none

module crl_result_reg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire crl_pkg::result_t  load_data,
    input  wire logic              out_ready,
    output logic                   out_valid,
    output logic                   free,
    output crl_pkg::result_t       data
);
    import crl_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign free       = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset; load only when the slot frees up.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign out_valid = valid_reg;
    assign data      = data_reg;

endmodule

`default_nettype wire

@@ sv/core_image_record_loader_top.sv @@
// Top level of the core image record loader: input register, parser, result register.
//
// Usage:
//   Input channel (in_valid/in_ready, byte_value, restart) carries one image byte
//   per transaction; set restart on the first byte of a new image to clear parsing.
//   Output channel (out_valid/out_ready, kind, target_address, word_value) carries
//   one result per completed 36-bit word that needs one: a memory write, a start
//   word, or a plain end. Record headers produce nothing.
//   cfg_wr_en/cfg_wr_data write start_jump_half; write only while the block is idle.
// Timing:
//   One byte per cycle sustained unless a byte that completes a result finds the
//   result register taken. A byte is held in the input register and is then parsed
//   into the result register by a single register-to-register parse step; out_valid
//   rises when the parse step that takes the fifth byte of its word loads it.
// Reset:
//   rst_n clears all parse state, both valid flags, and loads start_jump_half with
//   octal 254000.
// Stall:
//   While a result waits, bytes that complete no result still advance; a byte that
//   would produce a second result holds in the input register and in_ready drops.
`default_nettype none

module core_image_record_loader_top (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_wr_en,
    input  wire logic [crl_pkg::HALF_W-1:0]  cfg_wr_data,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [crl_pkg::BYTE_W-1:0]  byte_value,
    input  wire logic                        restart,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [1:0]                       kind,
    output logic [crl_pkg::HALF_W-1:0]       target_address,
    output logic [crl_pkg::WORD_W-1:0]       word_value
);
    import crl_pkg::*;

    logic [HALF_W-1:0] sjh_reg;

    // Input stage.
    logic              s1_valid_reg;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic              s1_restart_reg;

    logic              step;
    logic              res_valid;
    result_t           res;
    parse_status_t     status;
    logic              out_free;
    result_t           out_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sjh_reg <= START_JUMP_RESET;
        end
        else if (cfg_wr_en)
        begin
            sjh_reg <= cfg_wr_data;
        end
    end

    // Advance the parse step unless its result would find the output slot taken.
    assign step     = s1_valid_reg && (out_free || !res_valid);
    assign in_ready = !s1_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg    <= byte_value;
            s1_restart_reg <= restart;
        end
    end

    crl_parser u_parser (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (step),
        .byte_value      (s1_byte_reg),
        .restart         (s1_restart_reg),
        .start_jump_half (sjh_reg),
        .res_valid       (res_valid),
        .res             (res),
        .status          (status)
    );

    crl_result_reg u_result (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step && res_valid),
        .load_data (res),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .free      (out_free),
        .data      (out_data)
    );

    assign kind           = out_data.kind;
    assign target_address = out_data.target_address;
    assign word_value     = out_data.word_value;

    // Phase counter never passes the last byte of a word.
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        status.phase <= LAST_PHASE)
        else $error("byte phase out of range");

    // A memory write only comes out of an open record.
    a_write_in_record: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && res_valid && (res.kind == KIND_WRITE) |-> status.in_record)
        else $error("memory write outside a record");

    // A new result appears only after a parse step that produced one.
    a_out_from_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(step && res_valid))
        else $error("result appeared without a parse step");

    // Never overwrite a result the receiver has not taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("pending result lost");

endmodule

`default_nettype wire
